// ===== design/xbr_pkg.sv =====
// Package: shared types and constants for the xorshift64 bounded generator.
`timescale 1ns / 1ps

package xbr_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 6;
  localparam int OP_W   = 2;
  localparam int IN_TDATA_W = 136;

  localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'hDEAD_BEEF_CAFE_BABE;
  localparam int SHIFT_A   = 13;
  localparam int SHIFT_B   = 7;
  localparam int SHIFT_C   = 17;
  localparam int FRAC_DROP = 11;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_RAW     = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_FRAC    = 2'd2,
    OP_NONE    = 2'd3
  } xbr_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } xbr_bk_state_t;

  // one classified request between front and back
  typedef struct packed {
    logic              is_mod;  // 1: word needs reduction modulo range, then + low
    logic [WORD_W-1:0] word;    // stepped word, or the finished result
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] range;
  } xbr_cmd_t;

  function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] x;
    x = s;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage

// ===== design/xbr_front.sv =====
// Front end: holds generator state, accepts requests and classifies them.
`timescale 1ns / 1ps

module xbr_front import xbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_we,
  input  logic [WORD_W-1:0] seed_wdata,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [OP_W-1:0]   req_op,
  input  logic [WORD_W-1:0] req_low,
  input  logic [WORD_W-1:0] req_high,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output xbr_cmd_t          cmd
);

  logic [WORD_W-1:0] rng_state;
  logic [WORD_W-1:0] stepped;
  logic              do_step;
  logic              empty_range;

  assign stepped     = xs_step(rng_state);
  assign empty_range = $signed(req_high) <= $signed(req_low);
  assign req_ready   = cmd_ready;
  assign cmd_valid   = req_valid;

  always_comb begin
    do_step    = 1'b0;
    cmd.is_mod = 1'b0;
    cmd.word   = '0;
    cmd.low    = req_low;
    cmd.range  = req_high - req_low;
    unique case (xbr_op_t'(req_op))
      OP_RAW: begin
        do_step  = 1'b1;
        cmd.word = stepped;
      end
      OP_BOUNDED: begin
        if (empty_range) begin
          cmd.word = req_low;
        end else begin
          do_step    = 1'b1;
          cmd.is_mod = 1'b1;
          cmd.word   = stepped;
        end
      end
      OP_FRAC: begin
        do_step  = 1'b1;
        cmd.word = stepped >> FRAC_DROP;
      end
      default: cmd.word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= DEFAULT_SEED;
    end else if (seed_we) begin
      rng_state <= (seed_wdata != '0) ? seed_wdata : DEFAULT_SEED;
    end else if (req_valid && cmd_ready && do_step) begin
      rng_state <= stepped;
    end
  end

endmodule

// ===== design/xbr_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps

module xbr_queue import xbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  xbr_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop,
  output xbr_cmd_t pop_cmd
);

  xbr_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (pop)     rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== design/xbr_back.sv =====
// Back end: radix-2 remainder unit and result register.
`timescale 1ns / 1ps

module xbr_back import xbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  xbr_cmd_t          cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [WORD_W-1:0] res_value
);

  xbr_bk_state_t     state;
  xbr_bk_state_t     state_next;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] rem_next;
  logic [WORD_W-1:0] range;
  logic [WORD_W-1:0] low;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   trial;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem, dvd[WORD_W-1]};
  always_comb begin
    if (trial >= {1'b0, range}) rem_next = WORD_W'(trial - {1'b0, range});
    else                        rem_next = trial[WORD_W-1:0];
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = cmd.is_mod ? BK_DIV : BK_HOLD;
        end
      end
      BK_DIV: begin
        if (cnt == DIV_LAST) state_next = BK_HOLD;
      end
      BK_HOLD: begin
        res_valid = 1'b1;
        if (res_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid) begin
      if (cmd.is_mod) begin
        dvd   <= cmd.word;
        rem   <= '0;
        cnt   <= '0;
        low   <= cmd.low;
        range <= cmd.range;
      end else begin
        res_value <= cmd.word;
      end
    end else if (state == BK_DIV) begin
      dvd <= dvd << 1;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == DIV_LAST) res_value <= low + rem_next;
    end
  end

endmodule

// ===== design/xorshift64_bounded_rng_top.sv =====
// Top level: xorshift64 generator with raw, bounded and fraction requests.
`timescale 1ns / 1ps
// Flow: each accepted request is queued, then popped by the back end, which registers its
//   result; bounded requests first run the radix-2 remainder loop over all 64 dividend bits.
// Throughput: the back end takes no new request until its result is accepted, and a bounded
//   one holds it through the whole radix-2 remainder loop; the queue lets intake run ahead.
// Reset (rst, synchronous): state loads 0xDEADBEEFCAFEBABE, queue and back end empty.

module xorshift64_bounded_rng_top import xbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // seed register: a write reloads the generator; zero picks the default seed
  input  logic                  seed_we,
  input  logic [WORD_W-1:0]     seed_wdata,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // [1:0] op, [65:2] low_bound,
                                               // [129:66] high_bound, rest zero
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [WORD_W-1:0]     m_axis_tdata   // [63:0] value
);

  xbr_cmd_t front_cmd;
  xbr_cmd_t back_cmd;
  logic     front_valid;
  logic     q_ready;
  logic     q_valid;
  logic     q_pop;

  // Front: steps the generator at acceptance, so state order matches request order.
  xbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .req_valid  (s_axis_tvalid),
    .req_ready  (s_axis_tready),
    .req_op     (s_axis_tdata[OP_W-1:0]),
    .req_low    (s_axis_tdata[OP_W+WORD_W-1:OP_W]),
    .req_high   (s_axis_tdata[OP_W+2*WORD_W-1:OP_W+WORD_W]),
    .cmd_valid  (front_valid),
    .cmd_ready  (q_ready),
    .cmd        (front_cmd)
  );

  // Queue decouples request intake from the long remainder loop.
  xbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (q_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (back_cmd)
  );

  // Back: passes finished values through, or reduces word mod range and adds low.
  xbr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cmd        (back_cmd),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_value  (m_axis_tdata)
  );

endmodule

// ===== sim/testbench.sv =====
// Testbench: request stream checks of the xorshift64 bounded generator against a local predictor.
`timescale 1ns / 1ps

module testbench;
  import xbr_pkg::*;

  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          SETTLE_CYC  = 70;       // outlasts the longest bounded reduction
  localparam int          PHASE_ITEMS = 96;
  localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BOOT_SEED   = 64'hDEAD_BEEF_CAFE_BABE;
  localparam int          XS_LEFT1    = 13;
  localparam int          XS_RIGHT    = 7;
  localparam int          XS_LEFT2    = 17;
  localparam int          FRAC_SHIFT  = 11;

  // one request as the sender sees it; drain_first holds it back until
  // every outstanding result has come out
  typedef struct {
    xbr_op_t     op;
    logic [63:0] low_b;
    logic [63:0] high_b;
    bit          drain_first;
  } rng_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  seed_we = 1'b0;
  logic [WORD_W-1:0]     seed_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // [1:0] op, [65:2] low, [129:66] high
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;        // [63:0] value

  rng_req_t    pending_reqs[$];   // requests not yet offered
  logic [63:0] expected_vals[$];  // predicted values, oldest first
  rng_req_t    offered_req;       // request currently on the bus
  logic [63:0] rng_now;           // predictor copy of the generator state
  logic [63:0] got_want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int results_seen   = 0;
  int empty_ranges   = 0;
  int seeds_loaded   = 0;
  int op_count[4]    = '{0, 0, 0, 0};

  xorshift64_bounded_rng_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial forever #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s << XS_LEFT1);
    x = x ^ (x >> XS_RIGHT);
    x = x ^ (x << XS_LEFT2);
    return x;
  endfunction

  // Expected value of one request; steps rng_now where the block would.
  function automatic logic [63:0] predict_value(input rng_req_t r);
    logic [63:0] span;
    case (r.op)
      OP_RAW: begin
        rng_now = xorshift_next(rng_now);
        return rng_now;
      end
      OP_BOUNDED: begin
        // empty range: low comes back, generator holds
        if ($signed(r.high_b) <= $signed(r.low_b)) return r.low_b;
        span    = r.high_b - r.low_b;   // unsigned, may exceed the signed range
        rng_now = xorshift_next(rng_now);
        return r.low_b + (rng_now % span);
      end
      OP_FRAC: begin
        rng_now = xorshift_next(rng_now);
        return rng_now >> FRAC_SHIFT;
      end
      default: return '0;               // unused code: zero, no step
    endcase
  endfunction

  // ------------------------------------------------------------------ helpers

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(input xbr_op_t op, input logic [63:0] lo, input logic [63:0] hi,
                          input bit drain = 1'b0);
    rng_req_t r;
    r.op          = op;
    r.low_b       = lo;
    r.high_b      = hi;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endtask

  // Bounds for a bounded request: mostly non-empty ranges of assorted widths.
  task automatic push_bounded(input bit drain);
    logic [63:0] lo;
    logic [63:0] hi;
    case ($urandom_range(7))
      0: begin                                   // tiny range around zero
        lo = 64'($signed($urandom_range(2000)) - 1000);
        hi = lo + $urandom_range(1, 300);
      end
      1: begin                                   // tiny range anywhere
        lo = rand64();
        hi = lo + $urandom_range(1, 16);
      end
      2: begin                                   // fully random, half empty
        lo = rand64();
        hi = rand64();
      end
      3: begin                                   // wide: negative low, positive high
        lo = rand64() | S64_MIN;
        hi = rand64() & S64_MAX;
      end
      4: begin                                   // empty or equal bounds
        lo = rand64();
        hi = lo - $urandom_range(0, 5);
      end
      5: begin                                   // power-of-two span
        lo = rand64();
        hi = lo + (64'd1 << $urandom_range(62));
      end
      6: begin                                   // pinned to the signed extremes
        lo = $urandom_range(1) ? S64_MIN : rand64();
        hi = $urandom_range(1) ? S64_MAX : rand64();
      end
      default: begin                             // 32-bit-sized span
        lo = rand64();
        hi = lo + {32'd0, $urandom};
      end
    endcase
    push_req(OP_BOUNDED, lo, hi, drain);
  endtask

  // Wait until nothing is queued, offered or outstanding, then let the
  // back end run out its longest reduction.
  task automatic settle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_vals.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] s);
    @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= s;
    @(posedge clk);
    seed_we <= 1'b0;
    rng_now = (s != 64'd0) ? s : BOOT_SEED;   // zero selects the default seed
    seeds_loaded++;
  endtask

  task automatic run_phase(input logic [63:0] s, input int send_pct, input int recv_pct);
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    load_seed(s);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(99);
      // one request halfway through waits for a fully drained pipe
      if (pick < 25)      push_req(OP_RAW, rand64(), rand64(), i == PHASE_ITEMS / 2);
      else if (pick < 40) push_req(OP_FRAC, rand64(), rand64(), i == PHASE_ITEMS / 2);
      else if (pick < 45) push_req(OP_NONE, rand64(), rand64(), i == PHASE_ITEMS / 2);
      else                push_bounded(i == PHASE_ITEMS / 2);
    end
    settle();
  endtask

  // -------------------------------------------------------------------- driver
  // Predicts on acceptance, then offers the next request unless idling.

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (offered_req.op == OP_BOUNDED &&
            $signed(offered_req.high_b) <= $signed(offered_req.low_b))
          empty_ranges++;
        op_count[offered_req.op]++;
        expected_vals.push_back(predict_value(offered_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_reqs[0].drain_first && expected_vals.size() != 0)) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, offered_req.high_b, offered_req.low_b, offered_req.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_vals.size() == 0) begin
          report_mismatch("result with no request outstanding", m_axis_tdata, '0);
        end else begin
          got_want = expected_vals.pop_front();
          if (m_axis_tdata !== got_want)
            report_mismatch("value", m_axis_tdata, got_want);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------ watchdog

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_vals.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------ sequence

  initial begin
    rng_now = BOOT_SEED;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests from the reset seed: field extremes, every op code,
    // empty / equal / unit / wide / half-space ranges, ignored bound fields.
    push_req(OP_RAW,     '0,       '0);
    push_req(OP_RAW,     '1,       '1);
    push_req(OP_FRAC,    '0,       '0);
    push_req(OP_FRAC,    '1,       '1);
    push_req(OP_NONE,    '1,       '1);
    push_req(OP_BOUNDED, S64_MIN,  S64_MAX);
    push_req(OP_BOUNDED, S64_MAX,  S64_MIN);
    push_req(OP_BOUNDED, 64'd5,    64'd5);
    push_req(OP_BOUNDED, 64'd0,    64'd1);
    push_req(OP_BOUNDED, '1,       64'd0);
    push_req(OP_BOUNDED, -64'd10,  64'd10);
    push_req(OP_BOUNDED, S64_MIN,  S64_MIN + 64'd1);
    push_req(OP_BOUNDED, S64_MAX - 64'd1, S64_MAX);
    push_req(OP_BOUNDED, S64_MIN,  64'd0);
    push_req(OP_BOUNDED, '1,       S64_MAX);
    push_req(OP_BOUNDED, 64'd0,    S64_MAX);
    push_req(OP_BOUNDED, 64'd1000, 64'd1007, 1'b1);
    push_req(OP_BOUNDED, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);
    push_req(OP_BOUNDED, 64'hC000_0000_0000_0000, 64'h4000_0000_0000_0000);
    push_req(OP_NONE,    '0,       '0);
    push_req(OP_RAW,     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    settle();

    // Random phases: seed extremes and idling patterns on each side.
    run_phase('1,          0,  0);
    run_phase(64'd0,       70, 0);
    run_phase(64'd1,       0,  70);
    run_phase(S64_MIN,     17, 17);
    run_phase(rand64(),    0,  0);

    $display("covered %0d raw, %0d bounded (%0d empty range), %0d fraction, %0d unused-op",
             op_count[OP_RAW], op_count[OP_BOUNDED], empty_ranges, op_count[OP_FRAC],
             op_count[OP_NONE]);
    $display("%0d results checked over %0d seed loads, %0d mismatches",
             results_seen, seeds_loaded, error_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
